// File: rtl/core/clipped_premultiplied_pixel_blender_assert.svh
// assertion macros shared by the checker files
`ifndef CLIPPED_PREMULTIPLIED_PIXEL_BLENDER_ASSERT_SVH
`define CLIPPED_PREMULTIPLIED_PIXEL_BLENDER_ASSERT_SVH

// ante holds in a cycle, so cons holds in the same cycle; off during reset
`define CPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle, so cons holds in the next one; off during reset
`define CPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cond holds at every edge, reset included
`define CPB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// File: rtl/core/cpb_pkg.sv
`timescale 1ns / 1ps

package cpb_pkg;

    localparam int FRAME_SIZE = 4096;
    localparam int CLIP_W     = 13;
    localparam int COORD_W    = 12;
    localparam int ADDR_W     = 4;

    localparam logic [CLIP_W-1:0] CLIP_FULL = CLIP_W'(FRAME_SIZE);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_RECT   = 2'd1,
        OP_GLYPH  = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_RIGHT  = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CLIP_W-1:0] left;
        logic [CLIP_W-1:0] top;
        logic [CLIP_W-1:0] right;
        logic [CLIP_W-1:0] bottom;
    } clip_t;

    // after premultiply
    typedef struct packed {
        opcode_t     opcode;
        logic        in_clip;
        logic [31:0] bg;
        logic [23:0] straight;
        logic [23:0] premul;
        logic [7:0]  fg_alpha;
        logic [7:0]  texel;
        logic [7:0]  glyph_alpha;
    } s1_t;

    // after coverage scaling
    typedef struct packed {
        opcode_t     opcode;
        logic        in_clip;
        logic [31:0] bg;
        logic [23:0] straight;
        logic [31:0] fg_word;
        logic [7:0]  inv_alpha;
    } s2_t;

    // after background scaling
    typedef struct packed {
        opcode_t     opcode;
        logic        in_clip;
        logic [31:0] bg;
        logic [23:0] straight;
        logic [31:0] fg_word;
        logic [31:0] bg_scaled;
    } s3_t;

    function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] k);
        logic [15:0] prod;
        prod = 16'(v) * 16'(k);
        return prod[15:8];
    endfunction

endpackage

// File: rtl/core/clipped_premultiplied_pixel_blender.sv
// Per-pixel compositor: each item is one destination pixel with its old ARGB word, a
// straight drawing color, a glyph coverage byte and an opcode (clear, rectangle blend,
// glyph blit). It accepts one item every clock unless the output stalls, and returns
// one result per item; of the four register stages (premultiply, coverage scale,
// background scale, add and select) the first three each hold one level of 8 by 8
// multiplies and the last the 32-bit add, and a stall at the output backs up stage by
// stage, so bubbles close up and nothing is lost or repeated.
// The scissor registers sit on a small APB port at byte addresses 0 (left), 4 (top),
// 8 (right) and 12 (bottom), 13 bits each, and are meant to be written only while the
// pipeline is empty.
`timescale 1ns / 1ps

module clipped_premultiplied_pixel_blender (
    input  logic                        clk,
    input  logic                        rst_n,
    // scissor register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // pixel item in
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [cpb_pkg::COORD_W-1:0] pixel_x,
    input  logic [cpb_pkg::COORD_W-1:0] pixel_y,
    input  logic [31:0]                 bg_pixel,
    input  logic [7:0]                  fg_red,
    input  logic [7:0]                  fg_green,
    input  logic [7:0]                  fg_blue,
    input  logic [7:0]                  fg_alpha,
    input  logic [7:0]                  texel_alpha,
    // result item out
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        write_enable,
    output logic [31:0]                 pixel_out
);
    import cpb_pkg::*;

    clip_t clip;
    s1_t   s1_data;
    s2_t   s2_data;
    logic  s1_valid;
    logic  s1_ready;
    logic  s2_valid;
    logic  s2_ready;

    // scissor registers, reset to the whole frame
    cpb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .clip    (clip)
    );

    // stage 1: clip test and color times alpha, plus alpha times coverage
    cpb_premul u_premul (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (in_valid),
        .ready_in    (in_ready),
        .opcode      (opcode),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .bg_pixel    (bg_pixel),
        .fg_red      (fg_red),
        .fg_green    (fg_green),
        .fg_blue     (fg_blue),
        .fg_alpha    (fg_alpha),
        .texel_alpha (texel_alpha),
        .clip        (clip),
        .valid_out   (s1_valid),
        .ready_out   (s1_ready),
        .data_out    (s1_data)
    );

    // stage 2: glyph coverage applied, source word and inverse alpha formed
    cpb_glyph u_glyph (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .ready_in  (s1_ready),
        .data_in   (s1_data),
        .valid_out (s2_valid),
        .ready_out (s2_ready),
        .data_out  (s2_data)
    );

    // stages 3 and 4: background times inverse alpha, then 32-bit add and
    // opcode / clip selection into the output register
    cpb_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (s2_valid),
        .ready_in     (s2_ready),
        .data_in      (s2_data),
        .valid_out    (out_valid),
        .ready_out    (out_ready),
        .write_enable (write_enable),
        .pixel_out    (pixel_out)
    );

endmodule

// File: rtl/core/cpb_regs.sv
`timescale 1ns / 1ps

module cpb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cpb_pkg::clip_t             clip
);
    import cpb_pkg::*;

    clip_t      clip_reg;
    clip_t      clip_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign clip   = clip_reg;

    always_comb
    begin
        clip_next = clip_reg;
        if (wr_en)
        begin
            case (index)
                REG_CLIP_LEFT:   clip_next.left   = pwdata[CLIP_W-1:0];
                REG_CLIP_TOP:    clip_next.top    = pwdata[CLIP_W-1:0];
                REG_CLIP_RIGHT:  clip_next.right  = pwdata[CLIP_W-1:0];
                REG_CLIP_BOTTOM: clip_next.bottom = pwdata[CLIP_W-1:0];
                default:         clip_next = clip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= '0;
            clip_reg.top    <= '0;
            clip_reg.right  <= CLIP_FULL;
            clip_reg.bottom <= CLIP_FULL;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    always_comb
    begin
        case (index)
            REG_CLIP_LEFT:   prdata = {{(32-CLIP_W){1'b0}}, clip_reg.left};
            REG_CLIP_TOP:    prdata = {{(32-CLIP_W){1'b0}}, clip_reg.top};
            REG_CLIP_RIGHT:  prdata = {{(32-CLIP_W){1'b0}}, clip_reg.right};
            REG_CLIP_BOTTOM: prdata = {{(32-CLIP_W){1'b0}}, clip_reg.bottom};
            default:         prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/cpb_premul.sv
`timescale 1ns / 1ps

module cpb_premul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    output logic                        ready_in,
    input  logic [1:0]                  opcode,
    input  logic [cpb_pkg::COORD_W-1:0] pixel_x,
    input  logic [cpb_pkg::COORD_W-1:0] pixel_y,
    input  logic [31:0]                 bg_pixel,
    input  logic [7:0]                  fg_red,
    input  logic [7:0]                  fg_green,
    input  logic [7:0]                  fg_blue,
    input  logic [7:0]                  fg_alpha,
    input  logic [7:0]                  texel_alpha,
    input  cpb_pkg::clip_t              clip,
    output logic                        valid_out,
    input  logic                        ready_out,
    output cpb_pkg::s1_t                data_out
);
    import cpb_pkg::*;

    logic              valid_reg;
    s1_t               data_reg;
    s1_t               data_next;
    logic [CLIP_W-1:0] x_ext;
    logic [CLIP_W-1:0] y_ext;

    assign x_ext = {1'b0, pixel_x};
    assign y_ext = {1'b0, pixel_y};

    always_comb
    begin
        data_next.opcode      = opcode_t'(opcode);
        data_next.in_clip     = (x_ext >= clip.left) && (x_ext < clip.right)
                             && (y_ext >= clip.top) && (y_ext < clip.bottom);
        data_next.bg          = bg_pixel;
        data_next.straight    = {fg_red, fg_green, fg_blue};
        data_next.premul      = {scale8(fg_red, fg_alpha), scale8(fg_green, fg_alpha),
                                 scale8(fg_blue, fg_alpha)};
        data_next.fg_alpha    = fg_alpha;
        data_next.texel       = texel_alpha;
        data_next.glyph_alpha = scale8(fg_alpha, texel_alpha);
    end

    assign ready_in  = !valid_reg || ready_out;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/core/cpb_glyph.sv
`timescale 1ns / 1ps

module cpb_glyph (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid_in,
    output logic         ready_in,
    input  cpb_pkg::s1_t data_in,
    output logic         valid_out,
    input  logic         ready_out,
    output cpb_pkg::s2_t data_out
);
    import cpb_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    logic [7:0] fa;

    always_comb
    begin
        data_next.opcode   = data_in.opcode;
        data_next.in_clip  = data_in.in_clip;
        data_next.bg       = data_in.bg;
        data_next.straight = data_in.straight;
        // glyph scales the premultiplied color by coverage once more
        if (data_in.opcode == OP_GLYPH)
        begin
            fa = data_in.glyph_alpha;
            data_next.fg_word = {fa,
                                 scale8(data_in.premul[23:16], data_in.texel),
                                 scale8(data_in.premul[15:8], data_in.texel),
                                 scale8(data_in.premul[7:0], data_in.texel)};
        end
        else
        begin
            fa = data_in.fg_alpha;
            data_next.fg_word = {fa, data_in.premul};
        end
        data_next.inv_alpha = ~fa;
    end

    assign ready_in  = !valid_reg || ready_out;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/core/cpb_blend.sv
`timescale 1ns / 1ps

module cpb_blend (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid_in,
    output logic         ready_in,
    input  cpb_pkg::s2_t data_in,
    output logic         valid_out,
    input  logic         ready_out,
    output logic         write_enable,
    output logic [31:0]  pixel_out
);
    import cpb_pkg::*;

    // background scaling stage
    logic        s3_valid_reg;
    s3_t         s3_reg;
    s3_t         s3_next;
    logic        s3_ready;
    // result stage
    logic        out_valid_reg;
    logic        we_reg;
    logic        we_next;
    logic [31:0] pix_reg;
    logic [31:0] pix_next;
    logic        out_ready;
    logic [31:0] sum;

    always_comb
    begin
        s3_next.opcode    = data_in.opcode;
        s3_next.in_clip   = data_in.in_clip;
        s3_next.bg        = data_in.bg;
        s3_next.straight  = data_in.straight;
        s3_next.fg_word   = data_in.fg_word;
        s3_next.bg_scaled = {data_in.inv_alpha,
                             scale8(data_in.bg[23:16], data_in.inv_alpha),
                             scale8(data_in.bg[15:8], data_in.inv_alpha),
                             scale8(data_in.bg[7:0], data_in.inv_alpha)};
    end

    // carries between channels are part of the blend
    assign sum = s3_reg.fg_word + s3_reg.bg_scaled;

    always_comb
    begin
        we_next  = 1'b0;
        pix_next = s3_reg.bg;
        case (s3_reg.opcode)
            OP_CLEAR:
            begin
                we_next  = 1'b1;
                pix_next = {8'hFF, s3_reg.straight};
            end
            OP_RECT, OP_GLYPH:
            begin
                if (s3_reg.in_clip)
                begin
                    we_next  = 1'b1;
                    pix_next = sum;
                end
            end
            default:
            begin
                we_next  = 1'b0;
                pix_next = s3_reg.bg;
            end
        endcase
    end

    assign out_ready    = !out_valid_reg || ready_out;
    assign s3_ready     = !s3_valid_reg || out_ready;
    assign ready_in     = s3_ready;
    assign valid_out    = out_valid_reg;
    assign write_enable = we_reg;
    assign pixel_out    = pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= valid_in;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && valid_in)
        begin
            s3_reg <= s3_next;
        end
        if (out_ready && s3_valid_reg)
        begin
            we_reg  <= we_next;
            pix_reg <= pix_next;
        end
    end

endmodule

// File: rtl/core/cpb_checker.sv
`timescale 1ns / 1ps

`include "clipped_premultiplied_pixel_blender_assert.svh"

module cpb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [cpb_pkg::ADDR_W-1:0]  paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        write_enable,
    input logic [31:0]                 pixel_out
);
    import cpb_pkg::*;

    // a stalled result stays offered
    `CPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `CPB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(pixel_out) && $stable(write_enable), "result changed while stalled")

    // with nothing waiting at the output the pipeline takes a new item
    `CPB_ASSERT_SAME(a_ready_idle, !out_valid, in_ready, "input stalled with empty output")

    // a register reads back what was just written to it
    `CPB_ASSERT_SAME(a_readback, (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[3:2] == $past(paddr[3:2])), prdata[CLIP_W-1:0] == $past(pwdata[CLIP_W-1:0]) && prdata[31:CLIP_W] == '0, "register readback mismatch")

    // reset empties the pipeline
    `CPB_ASSERT_ALWAYS(a_reset_empty, rst_n || !out_valid, "result offered during reset")

endmodule

bind clipped_premultiplied_pixel_blender cpb_checker u_cpb_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cpb_pkg::*;

    localparam real CLK_PERIOD     = 12.0;
    localparam int  RESET_CYCLES   = 10;
    localparam int  PIPE_SLACK     = 8;     // four stages plus margin
    localparam int  HOLD_CYCLES    = 300;   // long output back-pressure stretch
    localparam int  STUCK_LIMIT    = 4000;  // cycles with no item moving on either side
    localparam int  PHASES         = 9;
    localparam int  ITEMS_PER_PHASE = 150;

    // one pixel item as offered on the input side
    typedef struct packed {
        opcode_t             op;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [31:0]         bg;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          alpha;
        logic [7:0]          texel;
    } pixel_item_t;

    // one result item as seen on the output side
    typedef struct packed {
        logic        write_enable;
        logic [31:0] pixel_out;
    } pixel_result_t;

    typedef enum logic {ROW_PIXEL, ROW_SCISSOR} row_kind_t;

    // directed stimulus row: either a pixel or a new scissor window
    typedef struct {
        row_kind_t     kind;
        clip_t         window;
        pixel_item_t   item;
        bit            typed;
        pixel_result_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b1;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode = '0;
    logic [COORD_W-1:0]  pixel_x = '0;
    logic [COORD_W-1:0]  pixel_y = '0;
    logic [31:0]         bg_pixel = '0;
    logic [7:0]          fg_red = '0;
    logic [7:0]          fg_green = '0;
    logic [7:0]          fg_blue = '0;
    logic [7:0]          fg_alpha = '0;
    logic [7:0]          texel_alpha = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                write_enable;
    logic [31:0]         pixel_out;

    // shadow copy of the scissor registers, starts at reset values
    clip_t scissor = '{left: '0, top: '0, right: CLIP_FULL, bottom: CLIP_FULL};

    pixel_result_t expected_pixels[$];
    stim_row_t     stim_table[$];
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            holds_requested = 0;
    int            holds_served = 0;
    int            hold_left = 0;
    int            stuck_cycles = 0;

    clipped_premultiplied_pixel_blender u_top (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // (v*k)>>8 on one 8-bit channel
    function automatic logic [7:0] channel_scale(logic [7:0] v, logic [7:0] k);
        logic [15:0] prod;
        prod = {8'd0, v} * {8'd0, k};
        return prod[15:8];
    endfunction

    // scale red, green and blue of a word by k, alpha byte becomes k
    function automatic logic [31:0] scale_channels(logic [31:0] w, logic [7:0] k);
        return {k, channel_scale(w[23:16], k), channel_scale(w[15:8], k),
                channel_scale(w[7:0], k)};
    endfunction

    function automatic pixel_result_t blend_pixel(pixel_item_t p);
        pixel_result_t res;
        logic [31:0]   fg;
        logic [31:0]   covered;
        logic [7:0]    inv;
        logic          in_window;
        in_window = {1'b0, p.x} >= scissor.left && {1'b0, p.x} < scissor.right
                 && {1'b0, p.y} >= scissor.top && {1'b0, p.y} < scissor.bottom;
        res.write_enable = 1'b0;
        res.pixel_out    = p.bg;
        case (p.op)
            OP_CLEAR:
            begin
                // opaque fill, scissor does not apply
                res.write_enable = 1'b1;
                res.pixel_out    = {8'hFF, p.red, p.green, p.blue};
            end
            OP_RECT, OP_GLYPH:
            begin
                fg = scale_channels({8'h00, p.red, p.green, p.blue}, p.alpha);
                if (p.op == OP_GLYPH)
                begin
                    // coverage scales the premultiplied color and the alpha
                    covered = scale_channels(fg, p.texel);
                    fg      = {channel_scale(p.alpha, p.texel), covered[23:0]};
                end
                if (in_window)
                begin
                    // source over, background alpha is dropped, sum wraps at 32 bits
                    inv              = 8'd255 - fg[31:24];
                    res.write_enable = 1'b1;
                    res.pixel_out    = fg + scale_channels(p.bg, inv);
                end
            end
            default:
            begin
                // unused opcode leaves the old word untouched
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // directed table construction
    // ------------------------------------------------------------------

    function automatic void pixel_row(opcode_t op, int x, int y, logic [31:0] bg,
                                      logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a, logic [7:0] t,
                                      bit typed, logic we, logic [31:0] word);
        stim_row_t row;
        row.kind   = ROW_PIXEL;
        row.window = scissor;
        row.item   = '{op: op, x: COORD_W'(x), y: COORD_W'(y), bg: bg, red: r,
                       green: g, blue: b, alpha: a, texel: t};
        row.typed  = typed;
        row.want   = '{write_enable: we, pixel_out: word};
        stim_table.push_back(row);
    endfunction

    function automatic void scissor_row(int l, int t, int r, int b);
        stim_row_t row;
        row.kind   = ROW_SCISSOR;
        row.window = '{left: CLIP_W'(l), top: CLIP_W'(t), right: CLIP_W'(r),
                       bottom: CLIP_W'(b)};
        row.item   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        stim_table.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------

    // coordinate biased toward the scissor edges on one axis
    function automatic logic [COORD_W-1:0] edge_coord(logic [CLIP_W-1:0] lo,
                                                      logic [CLIP_W-1:0] hi);
        logic [CLIP_W-1:0] c;
        case ($urandom_range(7))
            0:       c = lo - 1'b1;
            1:       c = lo;
            2:       c = hi - 1'b1;
            3:       c = hi;
            default: c = CLIP_W'($urandom_range(FRAME_SIZE - 1));
        endcase
        return c[COORD_W-1:0];
    endfunction

    // byte that hits 0 and 255 often, otherwise uniform
    function automatic logic [7:0] edgy_byte();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_item_t random_pixel();
        pixel_item_t p;
        int          pick;
        pick = $urandom_range(15);
        if (pick < 3)
            p.op = OP_CLEAR;
        else if (pick < 9)
            p.op = OP_RECT;
        else if (pick < 15)
            p.op = OP_GLYPH;
        else
            p.op = OP_UNUSED;
        p.x     = edge_coord(scissor.left, scissor.right);
        p.y     = edge_coord(scissor.top, scissor.bottom);
        p.bg    = $urandom;
        p.red   = 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
        p.alpha = edgy_byte();
        p.texel = edgy_byte();
        return p;
    endfunction

    // ------------------------------------------------------------------
    // input side and register port
    // ------------------------------------------------------------------

    // offer one pixel item, optionally after an idle gap, and record its
    // expected result once it is taken
    task automatic send_pixel(input pixel_item_t p, input bit typed,
                              input pixel_result_t typed_result);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= p.op;
        pixel_x     <= p.x;
        pixel_y     <= p.y;
        bg_pixel    <= p.bg;
        fg_red      <= p.red;
        fg_green    <= p.green;
        fg_blue     <= p.blue;
        fg_alpha    <= p.alpha;
        texel_alpha <= p.texel;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        // scissor is stable while items flow, so predicting here is safe
        expected_pixels.push_back(typed ? typed_result : blend_pixel(p));
    endtask

    // stop offering and let the pipeline empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // write all four scissor registers over the register port
    task automatic program_clip(input clip_t c);
        reg_index_t        idx;
        logic [CLIP_W-1:0] v;
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_index_t'(i);
            case (idx)
                REG_CLIP_LEFT:   v = c.left;
                REG_CLIP_TOP:    v = c.top;
                REG_CLIP_RIGHT:  v = c.right;
                REG_CLIP_BOTTOM: v = c.bottom;
                default:         v = '0;
            endcase
            // setup cycle, upper data bits sometimes carry junk that must be dropped
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(4 * idx);
            pwdata  <= {($urandom_range(1) ? (32 - CLIP_W)'($urandom) : '0), v};
            @(posedge clk);
            // access cycle, register takes the value at the next edge
            penable <= 1'b1;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scissor  = c;
    endtask

    // ------------------------------------------------------------------
    // output side: checker, random stall and the long hold-off
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : result_side
        pixel_result_t want;
        if (out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result item with no pixel pending: write_enable %0d pixel_out %08h",
                       write_enable, pixel_out);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %0d, got %0d",
                           want.write_enable, write_enable);
                    mismatches++;
                end
                if (pixel_out !== want.pixel_out)
                begin
                    $error("pixel_out: expected %08h, got %08h", want.pixel_out, pixel_out);
                    mismatches++;
                end
            end
        end
        // a new hold request starts a long stretch with ready low
        if (holds_served != holds_requested)
        begin
            holds_served <= holds_requested;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: ends the run when no item moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clip_t         window;
        int            l;
        int            t;
        pixel_result_t unused_result;

        // falling edge at time zero so the asynchronous reset takes hold at once
        rst_n <= 1'b0;

        unused_result = '0;

        // reset scissor covers the whole frame, so every rect and glyph is inside
        pixel_row(OP_CLEAR, 0, 0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  1, 1'b1, 32'hFF000000);
        pixel_row(OP_CLEAR, 4095, 4095, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  1, 1'b1, 32'hFFFFFFFF);
        // opaque white: background fully hidden, channels 254 after premultiply
        pixel_row(OP_RECT, 0, 0, 32'h12345678, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  1, 1'b1, 32'hFFFEFEFE);
        // fully transparent color over black and over white
        pixel_row(OP_RECT, 4095, 4095, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
                  1, 1'b1, 32'hFF000000);
        pixel_row(OP_RECT, 4095, 0, 32'hFFFFFFFF, 8'h5A, 8'hA5, 8'h3C, 8'h00, 8'h00,
                  1, 1'b1, 32'hFFFEFEFE);
        pixel_row(OP_RECT, 0, 4095, 32'h89ABCDEF, 8'h80, 8'h40, 8'hC0, 8'h80, 8'h00,
                  0, 1'b0, 32'h0);
        // zero coverage glyph leaves only the background
        pixel_row(OP_GLYPH, 17, 33, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  1, 1'b1, 32'hFF000000);
        pixel_row(OP_GLYPH, 1234, 2345, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  0, 1'b0, 32'h0);
        pixel_row(OP_GLYPH, 4095, 4095, 32'hAABBCCDD, 8'h11, 8'h77, 8'hEE, 8'hC8, 8'h80,
                  0, 1'b0, 32'h0);
        // unused opcode passes the old word through without a write
        pixel_row(OP_UNUSED, 10, 10, 32'hDEADBEEF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  1, 1'b0, 32'hDEADBEEF);

        // one-pixel scissor at (100, 200): probe every edge
        scissor_row(100, 200, 101, 201);
        pixel_row(OP_RECT, 100, 200, 32'h55667788, 8'h20, 8'hE0, 8'h90, 8'h7F, 8'h00,
                  0, 1'b0, 32'h0);
        pixel_row(OP_RECT, 99, 200, 32'h11223344, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  1, 1'b0, 32'h11223344);
        pixel_row(OP_RECT, 101, 200, 32'hCAFEF00D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  1, 1'b0, 32'hCAFEF00D);
        pixel_row(OP_GLYPH, 100, 199, 32'h0BADF00D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  1, 1'b0, 32'h0BADF00D);
        pixel_row(OP_GLYPH, 100, 201, 32'hFEEDFACE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  1, 1'b0, 32'hFEEDFACE);
        // clear ignores the scissor
        pixel_row(OP_CLEAR, 0, 0, 32'h00000000, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00,
                  1, 1'b1, 32'hFF123456);
        pixel_row(OP_GLYPH, 100, 200, 32'h80808080, 8'hF0, 8'h0F, 8'hAA, 8'hE0, 8'h40,
                  0, 1'b0, 32'h0);

        // inverted scissor: nothing is inside
        scissor_row(300, 0, 200, FRAME_SIZE);
        pixel_row(OP_RECT, 250, 10, 32'h13579BDF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  1, 1'b0, 32'h13579BDF);

        // reset, with every input already at a known value
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling on either side
        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_SCISSOR)
            begin
                wait_drained();
                program_clip(stim_table[i].window);
            end
            else
            begin
                send_pixel(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
            end
        end

        // random phases, each with its own scissor and idling pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0: window = '{left: '0, top: '0, right: CLIP_FULL, bottom: CLIP_FULL};
                2:
                begin
                    // empty: left equals right
                    l      = $urandom_range(FRAME_SIZE);
                    window = '{left: CLIP_W'(l), top: '0, right: CLIP_W'(l),
                               bottom: CLIP_FULL};
                end
                3:
                begin
                    // inverted on both axes
                    window = '{left: CLIP_W'(3000), top: CLIP_W'(4000), right: CLIP_W'(1000),
                               bottom: CLIP_W'(5)};
                end
                4: window = '{left: '1, top: '1, right: '1, bottom: '1};
                5: window = '{left: '0, top: '0, right: '1, bottom: '1};
                6:
                begin
                    // only the last pixel of the frame
                    window = '{left: CLIP_W'(FRAME_SIZE - 1), top: CLIP_W'(FRAME_SIZE - 1),
                               right: CLIP_FULL, bottom: CLIP_FULL};
                end
                7: window = '0;
                default:
                begin
                    l      = $urandom_range(3500);
                    t      = $urandom_range(3500);
                    window = '{left: CLIP_W'(l), top: CLIP_W'(t),
                               right: CLIP_W'(l + $urandom_range(1, FRAME_SIZE - l)),
                               bottom: CLIP_W'(t + $urandom_range(1, FRAME_SIZE - t))};
                end
            endcase
            program_clip(window);

            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase

            // first phase: output holds off while input keeps pushing, pipeline fills
            if (phase == 0)
                holds_requested <= holds_requested + 1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_pixel(random_pixel(), 1'b0, unused_result);
        end

        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
